// File: design/lzw_pkg.sv
// lzw_pkg: shared types and constants for the lzw byte stream encoder
// used by all design files, no dependencies

package lzw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT,
        ST_FINAL,
        ST_PAD,
        ST_DRAIN
    } t_state;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CW_W   = 4;
    localparam logic [CW_W-1:0] CW_MIN = 4'd9;

endpackage

// File: design/lzw_dict.sv
// lzw_dict: dictionary key memory, one write port, one registered read port
// depends on lzw_pkg

module lzw_dict
    import lzw_pkg::*;
#(
    parameter int unsigned AW = 12,
    parameter int unsigned KW = 20
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [KW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [KW-1:0] o_rdata
);

    logic [KW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/lzw_packer.sv
// lzw_packer: bit accumulator that shifts codes in msb first and pops bytes
// depends on lzw_pkg

module lzw_packer
    import lzw_pkg::*;
#(
    parameter int unsigned CODE_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [CODE_W-1:0] i_code,
    input  logic [CW_W-1:0]   i_width,
    input  logic              i_pad,
    input  logic              i_pop,
    input  logic              i_clear,
    output logic              o_has_byte,
    output logic              o_has_bits,
    output logic              o_last_byte,
    output logic [BYTE_W-1:0] o_byte
);

    localparam int unsigned ACC_W = CODE_W + 7;
    localparam int unsigned CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0] w_mask;
    logic [ACC_W-1:0] w_top;

    assign w_mask      = (ACC_W'(1) << i_width) - ACC_W'(1);
    assign o_has_byte  = r_cnt >= CNT_W'(BYTE_W);
    assign o_has_bits  = r_cnt != '0;
    // exactly one byte left in the accumulator
    assign o_last_byte = r_cnt == CNT_W'(BYTE_W);
    assign w_top       = r_acc >> (r_cnt - CNT_W'(BYTE_W));
    assign o_byte      = w_top[BYTE_W-1:0];

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_clear) begin
            n_acc = '0;
            n_cnt = '0;
        end else if (i_load) begin
            n_acc = (r_acc << i_width) | (ACC_W'(i_code) & w_mask);
            n_cnt = r_cnt + CNT_W'(i_width);
        end else if (i_pad) begin
            // zero fill the partial byte
            n_acc = r_acc << (CNT_W'(BYTE_W) - r_cnt);
            n_cnt = CNT_W'(BYTE_W);
        end else if (i_pop) begin
            n_cnt = r_cnt - CNT_W'(BYTE_W);
            n_acc = r_acc & ((ACC_W'(1) << n_cnt) - ACC_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/lzw_byte_stream_encoder_core.sv
// lzw_byte_stream_encoder_core: top level of the lzw encoder
// depends on lzw_pkg, lzw_dict, lzw_packer

// Each input byte after the first of a stream is looked up by a sequential scan
// of the dictionary memory, one entry per cycle through its single registered
// read port. Codes are packed msb first at code_width bits (9..MAX_CODE_BITS),
// the stream end flushes the last code and zero pads, marking the final byte
// with tlast. The dictionary needs no clearing pass: only entries below
// next_code are read.
module lzw_byte_stream_encoder_core
    import lzw_pkg::*;
#(
    parameter int unsigned MAX_CODE_BITS = 12,
    parameter int unsigned ALPHABET_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CW_W-1:0]   i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // in_byte
    input  logic              s_axis_tlast,   // in_last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // out_byte
    output logic              m_axis_tlast    // out_last
);

    localparam int unsigned CODE_W = MAX_CODE_BITS;
    localparam int unsigned NC_W   = MAX_CODE_BITS + 1;
    localparam int unsigned KEY_W  = MAX_CODE_BITS + BYTE_W;
    localparam logic [NC_W-1:0] ALPHA = NC_W'(ALPHABET_SIZE);

    t_state r_state, n_state;
    logic [CW_W-1:0]   r_cw;
    logic [CODE_W-1:0] r_prefix, n_prefix;
    logic              r_pvalid, n_pvalid;
    logic [NC_W-1:0]   r_next, n_next;
    logic [NC_W-1:0]   r_scan, n_scan;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_rdv, n_rdv;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_ovalid, r_olast;

    logic [CW_W-1:0]   w_width;
    logic [NC_W-1:0]   w_cap;
    logic [NC_W-1:0]   w_next_chk;
    logic [KEY_W-1:0]  w_key, w_rdata;
    logic              w_we, w_load, w_pad, w_pop, w_clear;
    logic [CODE_W-1:0] w_code;
    logic              w_has_byte, w_has_bits, w_last_byte;
    logic [BYTE_W-1:0] w_pbyte;
    logic [BYTE_W-1:0] w_inb;
    logic [NC_W-1:0]   w_rd_code;
    logic              w_out_free;

    always_comb begin
        w_width = r_cw;
        if (r_cw < CW_MIN) w_width = CW_MIN;
        if (int'(r_cw) > MAX_CODE_BITS) w_width = CW_W'(MAX_CODE_BITS);
    end
    assign w_cap      = NC_W'(1) << w_width;
    assign w_next_chk = (r_next >= w_cap) ? ALPHA : r_next;
    assign w_key      = {r_prefix, r_byte};
    assign w_inb      = (NC_W'(s_axis_tdata) >= ALPHA) ? BYTE_W'(ALPHABET_SIZE - 1)
                                                       : s_axis_tdata;
    assign w_rd_code  = r_scan - NC_W'(1);
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cw <= 4'd12;
        else if (i_cfg_we) r_cw <= i_cfg_wdata;
    end

    lzw_dict #(.AW(MAX_CODE_BITS), .KW(KEY_W)) u_dict (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_next[MAX_CODE_BITS-1:0]),
        .i_wdata(w_key),
        .i_raddr(r_scan[MAX_CODE_BITS-1:0]),
        .o_rdata(w_rdata)
    );

    lzw_packer #(.CODE_W(CODE_W)) u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_code     (w_code),
        .i_width    (w_width),
        .i_pad      (w_pad),
        .i_pop      (w_pop),
        .i_clear    (w_clear),
        .o_has_byte (w_has_byte),
        .o_has_bits (w_has_bits),
        .o_last_byte(w_last_byte),
        .o_byte     (w_pbyte)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (!r_pvalid) n_state = s_axis_tlast ? ST_FINAL : ST_IDLE;
                    else n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_rdv && w_rdata == w_key)
                    n_state = r_last ? ST_FINAL : ST_IDLE;
                else if (r_scan >= r_next)
                    n_state = ST_EMIT;
            end
            ST_EMIT:  n_state = ST_DRAIN;
            ST_FINAL: n_state = ST_PAD;
            ST_PAD: begin
                if (!w_has_byte && w_out_free) begin
                    n_state = w_has_bits ? ST_PAD : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (!w_has_byte) n_state = r_last ? ST_FINAL : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_prefix = r_prefix;
        n_pvalid = r_pvalid;
        n_next   = r_next;
        n_scan   = r_scan;
        n_byte   = r_byte;
        n_last   = r_last;
        n_rdv    = 1'b0;
        w_we     = 1'b0;
        w_load   = 1'b0;
        w_pad    = 1'b0;
        w_pop    = 1'b0;
        w_clear  = 1'b0;
        w_code   = r_prefix;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_byte = w_inb;
                    n_last = s_axis_tlast;
                    n_next = w_next_chk;
                    n_scan = ALPHA;
                    if (!r_pvalid) begin
                        n_prefix = CODE_W'(w_inb);
                        n_pvalid = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                // read issued at r_scan, compared in the next cycle
                if (r_rdv && w_rdata == w_key) begin
                    n_prefix = w_rd_code[CODE_W-1:0];
                end else if (r_scan < r_next) begin
                    n_scan = r_scan + NC_W'(1);
                    n_rdv  = 1'b1;
                end
            end
            ST_EMIT: begin
                w_load   = 1'b1;
                w_we     = 1'b1;
                n_next   = (r_next + NC_W'(1) >= w_cap) ? ALPHA : r_next + NC_W'(1);
                n_prefix = CODE_W'(r_byte);
            end
            ST_FINAL: w_load = 1'b1;
            ST_PAD: begin
                if (w_out_free) begin
                    if (w_has_byte) w_pop = 1'b1;
                    else if (w_has_bits) w_pad = 1'b1;
                    else begin
                        w_clear  = 1'b1;
                        n_prefix = '0;
                        n_pvalid = 1'b0;
                        n_next   = ALPHA;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_free && w_has_byte) w_pop = 1'b1;
            end
            default: ;
        endcase
    end

    // output register, final byte is the pop in the pad state that leaves nothing behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_pop) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_pop) begin
            r_obyte <= w_pbyte;
            r_olast <= (r_state == ST_PAD) && w_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pvalid <= 1'b0;
            r_next   <= ALPHA;
            r_prefix <= '0;
            r_rdv    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_next   <= n_next;
            r_prefix <= n_prefix;
            r_rdv    <= n_rdv;
        end
        r_scan <= n_scan;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next >= ALPHA) else $error("next code below alphabet");
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_out_free) else $error("pop into full output");

endmodule
